>>> hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg - shared types and constants of the filtered-derivative PID block
// Operand and accumulator widths of the shared multiplier, the product
// sequence, the controller states and the configuration register indexes.
// ----------------------------------------------------------------------------
package pfd_pkg;

    // Wide operand of the shared multiplier, split into two 32-bit halves.
    localparam int XW     = 64;
    localparam int HALF_W = 32;
    localparam int COEF_W = 33;
    // Two partial products of a 33x33 multiplier, accumulated high half first.
    localparam int MAC_W  = 98;

    // Fixed widths of the integrator, low-pass state and product terms.
    localparam int ACC_W  = 48;
    localparam int TERM_W = 62;

    typedef logic signed [XW-1:0]     xop_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic en;   // multiplier result is captured this cycle
        logic lo;   // low half: shift the accumulator and add
    } mac_ctrl_t;

    // Order of the seven products of one request.
    typedef enum logic [2:0] {
        OP_SCALE = 3'd0,   // measured * deriv_scale
        OP_LPFB  = 3'd1,   // filt_den * previous low-pass output
        OP_INTEG = 3'd2,   // integ_step * (error + previous error)
        OP_LPIN  = 3'd3,   // filt_num * (scaled + previous scaled)
        OP_PROP  = 3'd4,   // prop_gain * error
        OP_IGAIN = 3'd5,   // integ_gain * integral
        OP_DGAIN = 3'd6    // deriv_gain * derivative
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_HI   = 5'b00100,
        ST_LO   = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_NUM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_DEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_SCALE = 3'd6;

    localparam logic [15:0] DERIV_SCALE_RESET = 16'd150;

endpackage

>>> hw/rtl/pfd_mac.sv
// ----------------------------------------------------------------------------
// pfd_mac - shared multiply-accumulate unit
// Multiplies a 64-bit operand by a 33-bit coefficient in two passes of a
// 33x33 signed multiplier and presents the product floored by the fraction
// shift and saturated to the term width, and unshifted saturated to 48 bits.
// ----------------------------------------------------------------------------
module pfd_mac #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                clk,
    input  pfd_pkg::mac_ctrl_t                  ctrl,
    input  pfd_pkg::xop_t                       x,
    input  pfd_pkg::coef_t                      coef,
    output logic signed [pfd_pkg::TERM_W-1:0]   term,
    output logic signed [pfd_pkg::ACC_W-1:0]    full
);

    localparam int MW = pfd_pkg::MAC_W;
    localparam int TW = pfd_pkg::TERM_W;
    localparam int AW = pfd_pkg::ACC_W;
    localparam int HW = pfd_pkg::HALF_W;
    localparam int CW = pfd_pkg::COEF_W;

    localparam logic signed [MW-1:0] T_MAX = {{(MW-TW+1){1'b0}}, {(TW-1){1'b1}}};
    localparam logic signed [MW-1:0] T_MIN = {{(MW-TW+1){1'b1}}, {(TW-1){1'b0}}};
    localparam logic signed [MW-1:0] F_MAX = {{(MW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [MW-1:0] F_MIN = {{(MW-AW+1){1'b1}}, {(AW-1){1'b0}}};

    logic signed [CW-1:0]   chunk;
    logic signed [2*CW-1:0] prod;
    logic signed [MW-1:0]   acc_reg;
    logic signed [MW-1:0]   acc_next;
    logic signed [MW-1:0]   shifted;

    // The high half carries the sign, the low half is taken as unsigned.
    assign chunk = ctrl.lo ? {1'b0, x[HW-1:0]} : {x[2*HW-1], x[2*HW-1:HW]};
    assign prod  = chunk * coef;

    assign acc_next = ctrl.lo ? (acc_reg <<< HW) + MW'(prod) : MW'(prod);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Arithmetic shift of the exact product floors toward minus infinity.
    assign shifted = acc_reg >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (shifted > T_MAX)
        begin
            term = T_MAX[TW-1:0];
        end
        else if (shifted < T_MIN)
        begin
            term = T_MIN[TW-1:0];
        end
        else
        begin
            term = shifted[TW-1:0];
        end

        if (acc_reg > F_MAX)
        begin
            full = F_MAX[AW-1:0];
        end
        else if (acc_reg < F_MIN)
        begin
            full = F_MIN[AW-1:0];
        end
        else
        begin
            full = acc_reg[AW-1:0];
        end
    end

endmodule

>>> hw/rtl/pid_filtered_derivative.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative - PID controller with filtered derivative
// Each request carries a setpoint and a measurement in signed Q16.16 and
// yields one saturated drive value with a clamp flag. All seven products
// (derivative scaling, two low-pass products, the trapezoidal integrator
// step and the three gains) run one after another on a single shared
// 33x33 multiplier, in a high and a low pass since each wide operand is
// fed in two 32-bit halves. A request is accepted, its error is formed,
// the seven products run on the multiplier, and the terms are summed and
// clamped; the next request is accepted only after the result is written.
// in_ready is high only while no request is in work; a finished result
// waits in the output register, and the next request is accepted but holds
// in its final step until that result is taken. Configuration writes take
// effect at once and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module pid_filtered_derivative #(
    parameter int DATA_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [DATA_WIDTH-1:0]        setpoint,
    input  logic signed [DATA_WIDTH-1:0]        measured,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [DATA_WIDTH-1:0]        drive,
    output logic                                saturated,

    input  logic                                cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int DW = DATA_WIDTH;
    localparam int EW = DATA_WIDTH + 1;
    localparam int XW = pfd_pkg::XW;
    localparam int AW = pfd_pkg::ACC_W;
    localparam int TW = pfd_pkg::TERM_W;
    localparam int SW = pfd_pkg::ACC_W + 1;

    localparam logic signed [DW:0] D_MAX = {2'b00, {(DW-1){1'b1}}};
    localparam logic signed [DW:0] D_MIN = {2'b11, {(DW-1){1'b0}}};
    localparam logic signed [XW:0] O_MAX = 65'(D_MAX);
    localparam logic signed [XW:0] O_MIN = 65'(D_MIN);
    localparam logic signed [XW+1:0] E_MAX = {3'b000, {(XW-1){1'b1}}};
    localparam logic signed [XW+1:0] E_MIN = {3'b111, {(XW-1){1'b0}}};
    localparam logic signed [TW:0] A_MAX = {{(TW-AW+2){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [TW:0] A_MIN = {{(TW-AW+2){1'b1}}, {(AW-1){1'b0}}};

    function automatic logic signed [AW-1:0] sat_acc(input logic signed [TW:0] v);
        logic signed [AW-1:0] r;
        if (v > A_MAX)
        begin
            r = A_MAX[AW-1:0];
        end
        else if (v < A_MIN)
        begin
            r = A_MIN[AW-1:0];
        end
        else
        begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

    // Control.
    pfd_pkg::state_t state_reg, state_next;
    pfd_pkg::op_t    op_reg, op_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_fire;
    logic            fin_fire;

    // Configuration registers.
    logic signed [31:0] prop_gain_reg;
    logic signed [31:0] integ_gain_reg;
    logic signed [31:0] deriv_gain_reg;
    logic        [30:0] integ_step_reg;
    logic signed [31:0] filt_num_reg;
    logic signed [31:0] filt_den_reg;
    logic        [15:0] deriv_scale_reg;

    // Controller state carried from one request to the next.
    logic signed [AW-1:0] integ_reg;
    logic signed [DW-1:0] prev_err_reg;
    logic signed [AW-1:0] prev_s_reg;
    logic signed [AW-1:0] lp_reg;

    // Working registers of one request.
    logic signed [DW-1:0] sp_reg;
    logic signed [DW-1:0] ms_reg;
    logic signed [DW-1:0] err_reg;
    logic signed [XW-1:0] esum_reg;
    logic signed [AW-1:0] scaled_reg;
    logic signed [SW-1:0] ssum_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [SW-1:0] deriv_reg;
    logic signed [XW-1:0] sum_reg;
    logic signed [DW-1:0] drive_reg;
    logic                 sat_reg;

    // Datapath.
    logic signed [DW:0]   diff;
    logic signed [DW-1:0] err_next;
    logic signed [XW+1:0] esum_w;
    logic signed [XW-1:0] esum_next;
    logic signed [SW-1:0] ssum_next;
    logic signed [AW-1:0] integ_next;
    logic signed [AW-1:0] lp_next;
    logic signed [SW-1:0] deriv_next;
    logic signed [XW-1:0] psum;
    logic signed [XW:0]   total;
    logic signed [DW-1:0] drive_next;
    logic                 sat_next;

    pfd_pkg::mac_ctrl_t   mac_ctrl;
    pfd_pkg::xop_t        mac_x;
    pfd_pkg::coef_t       mac_coef;
    logic signed [TW-1:0] mac_term;
    logic signed [AW-1:0] mac_full;

    assign in_ready  = (state_reg == pfd_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign fin_fire  = (state_reg == pfd_pkg::ST_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

    // Sequencer: capture, form the error, seven products, then sum and clamp.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            pfd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pfd_pkg::ST_PREP;
                end
            end
            pfd_pkg::ST_PREP:
            begin
                op_next    = pfd_pkg::OP_SCALE;
                state_next = pfd_pkg::ST_HI;
            end
            pfd_pkg::ST_HI:
            begin
                state_next = pfd_pkg::ST_LO;
            end
            pfd_pkg::ST_LO:
            begin
                if (op_reg == pfd_pkg::OP_DGAIN)
                begin
                    state_next = pfd_pkg::ST_FIN;
                end
                else
                begin
                    op_next    = pfd_pkg::op_t'(op_reg + 3'd1);
                    state_next = pfd_pkg::ST_HI;
                end
            end
            pfd_pkg::ST_FIN:
            begin
                if (fin_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = pfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfd_pkg::ST_IDLE;
            op_reg        <= pfd_pkg::OP_SCALE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_step_reg  <= '0;
            filt_num_reg    <= '0;
            filt_den_reg    <= '0;
            deriv_scale_reg <= pfd_pkg::DERIV_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfd_pkg::CFG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                pfd_pkg::CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                pfd_pkg::CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                pfd_pkg::CFG_INTEG_STEP:  integ_step_reg  <= cfg_wdata[30:0];
                pfd_pkg::CFG_FILT_NUM:    filt_num_reg    <= cfg_wdata;
                pfd_pkg::CFG_FILT_DEN:    filt_den_reg    <= cfg_wdata;
                pfd_pkg::CFG_DERIV_SCALE: deriv_scale_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Operand and coefficient of the product in work.
    always_comb
    begin
        case (op_reg)
            pfd_pkg::OP_SCALE:
            begin
                mac_x    = pfd_pkg::xop_t'(ms_reg);
                mac_coef = {17'd0, deriv_scale_reg};
            end
            pfd_pkg::OP_LPFB:
            begin
                mac_x    = pfd_pkg::xop_t'(lp_reg);
                mac_coef = pfd_pkg::coef_t'(filt_den_reg);
            end
            pfd_pkg::OP_INTEG:
            begin
                mac_x    = esum_reg;
                mac_coef = {2'b00, integ_step_reg};
            end
            pfd_pkg::OP_LPIN:
            begin
                mac_x    = pfd_pkg::xop_t'(ssum_reg);
                mac_coef = pfd_pkg::coef_t'(filt_num_reg);
            end
            pfd_pkg::OP_PROP:
            begin
                mac_x    = pfd_pkg::xop_t'(err_reg);
                mac_coef = pfd_pkg::coef_t'(prop_gain_reg);
            end
            pfd_pkg::OP_IGAIN:
            begin
                mac_x    = pfd_pkg::xop_t'(integ_reg);
                mac_coef = pfd_pkg::coef_t'(integ_gain_reg);
            end
            pfd_pkg::OP_DGAIN:
            begin
                mac_x    = pfd_pkg::xop_t'(deriv_reg);
                mac_coef = pfd_pkg::coef_t'(deriv_gain_reg);
            end
            default:
            begin
                mac_x    = '0;
                mac_coef = '0;
            end
        endcase
    end

    assign mac_ctrl.en = (state_reg == pfd_pkg::ST_HI) || (state_reg == pfd_pkg::ST_LO);
    assign mac_ctrl.lo = (state_reg == pfd_pkg::ST_LO);

    pfd_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .x    (mac_x),
        .coef (mac_coef),
        .term (mac_term),
        .full (mac_full)
    );

    always_comb
    begin
        diff = EW'(sp_reg) - EW'(ms_reg);
        if (diff > D_MAX)
        begin
            err_next = D_MAX[DW-1:0];
        end
        else if (diff < D_MIN)
        begin
            err_next = D_MIN[DW-1:0];
        end
        else
        begin
            err_next = diff[DW-1:0];
        end

        // Only a data path of at least 64 bits can push this sum out of range.
        esum_w = 66'(err_reg) + 66'(prev_err_reg);
        if (esum_w > E_MAX)
        begin
            esum_next = E_MAX[XW-1:0];
        end
        else if (esum_w < E_MIN)
        begin
            esum_next = E_MIN[XW-1:0];
        end
        else
        begin
            esum_next = esum_w[XW-1:0];
        end

        ssum_next  = SW'(scaled_reg) + SW'(prev_s_reg);
        integ_next = sat_acc(63'(integ_reg) + 63'(mac_term));
        lp_next    = sat_acc(63'(mac_term) - 63'(t2_reg));
        deriv_next = SW'(scaled_reg) - SW'(lp_reg);

        // Three terms of at most 62 bits cannot overflow 64 bits.
        psum  = sum_reg + XW'(mac_term);
        total = 65'(psum);
        if (total > O_MAX)
        begin
            drive_next = O_MAX[DW-1:0];
            sat_next   = 1'b1;
        end
        else if (total < O_MIN)
        begin
            drive_next = O_MIN[DW-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = total[DW-1:0];
            sat_next   = 1'b0;
        end
    end

    // While the next product starts, the result of the previous one is used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
            prev_s_reg   <= '0;
            lp_reg       <= '0;
        end
        else
        begin
            if ((state_reg == pfd_pkg::ST_HI) && (op_reg == pfd_pkg::OP_LPIN))
            begin
                integ_reg <= integ_next;
            end
            if ((state_reg == pfd_pkg::ST_HI) && (op_reg == pfd_pkg::OP_PROP))
            begin
                lp_reg <= lp_next;
            end
            if (fin_fire)
            begin
                prev_err_reg <= err_reg;
                prev_s_reg   <= scaled_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sp_reg <= setpoint;
            ms_reg <= measured;
        end
        if (state_reg == pfd_pkg::ST_PREP)
        begin
            err_reg <= err_next;
        end
        if (state_reg == pfd_pkg::ST_HI)
        begin
            case (op_reg)
                pfd_pkg::OP_LPFB:
                begin
                    scaled_reg <= mac_full;
                    esum_reg   <= esum_next;
                end
                pfd_pkg::OP_INTEG:
                begin
                    t2_reg   <= mac_term;
                    ssum_reg <= ssum_next;
                end
                pfd_pkg::OP_IGAIN:
                begin
                    sum_reg   <= XW'(mac_term);
                    deriv_reg <= deriv_next;
                end
                pfd_pkg::OP_DGAIN:
                begin
                    sum_reg <= psum;
                end
                default: ;
            endcase
        end
        if (fin_fire)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

endmodule
